FILE: rtl/srsw_pkg.sv
// shared types, codes and constants of the selective repeat sender window
package srsw_pkg;

  localparam int SEQ_COUNT_DEF = 20;
  localparam int WINDOW_W      = 4;
  localparam int COUNT_W       = 16;
  localparam int ACK_W         = 8;
  localparam int FIELD_SLOT_W  = 5;
  localparam int CALC_W        = 9;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 4'd10;
  localparam logic [COUNT_W-1:0]  TOTAL_RESET  = 16'd0;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_SEND    = 2'd1,
    KIND_ACK     = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE   = 1'b0,
    CFG_TOTAL_PACKETS = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SLIDE,
    ST_RESULT
  } ctrl_state_t;

  typedef struct packed {
    kind_t              kind;
    logic [ACK_W-1:0]   ack_number;
  } in_item_t;

  typedef struct packed {
    logic                    granted;
    logic [FIELD_SLOT_W-1:0] wire_seq;
    logic [COUNT_W-1:0]      packet_index;
    logic                    transfer_done;
    logic                    ack_ignored;
    logic [FIELD_SLOT_W-1:0] window_base;
    logic [FIELD_SLOT_W-1:0] next_slot;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic slide_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic slide_stop;
  } dp_status_t;

endpackage

FILE: rtl/selective_repeat_sender_window.sv
// top level of the selective repeat sender window
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------
//  in_     | input     | in_valid / in_ready       | in_item_t  (kind, ack_number)
//  out_    | output    | out_valid / out_ready     | out_item_t (grant, seq, status)
//  cfg_    | input     | cfg_we, no wait           | cfg_index, cfg_data
//
// one item at a time: accept, execute, base slide and result load come before the
// next accept; an ack for the base slides it over freed slots (at most the window)
// result sits in an output register, a new item is taken while it waits
// a full output register holds the finished result until out_ready
// reset is synchronous, active low: bitmap all free, base/next/count zero,
// window 10, total packets 0; no clearing pass is needed
module selective_repeat_sender_window
  import srsw_pkg::*;
#(
  parameter int SEQ_COUNT = SEQ_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // item input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  // result output
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  // config writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: accept, execute, slide the base, load the result
  srsw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // window state, bitmap and result register
  srsw_dpath #(
    .SEQ_COUNT (SEQ_COUNT)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_item  (out_item),
    .cmd       (cmd),
    .status    (status)
  );

  // only one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in progress");

  // a grant never comes with a rejected ack
  a_grant_vs_ignore: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.granted) |-> !out_item.ack_ignored)
    else $error("grant and ack rejection in the same result");

  // no grant means no sequence and no index
  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.granted) |->
      (out_item.wire_seq == '0 && out_item.packet_index == '0))
    else $error("sequence or index given without a grant");

endmodule

FILE: rtl/srsw_ctrl.sv
// controller state machine: sequences accept, execute, base slide and result load
module srsw_ctrl
  import srsw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_SLIDE;
      end
      ST_SLIDE: begin
        if (status.slide_stop) begin
          state_nxt = ST_RESULT;
        end else begin
          cmd.slide_step = 1'b1;
        end
      end
      ST_RESULT: begin
        // wait for the output register to drain
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/srsw_dpath.sv
// datapath: window state, slot bitmap, config registers and result register
module srsw_dpath
  import srsw_pkg::*;
#(
  parameter int SEQ_COUNT = SEQ_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_item,
  output out_item_t             out_item,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status
);

  localparam int SLOT_W = $clog2(SEQ_COUNT);
  localparam int EW     = (SLOT_W + 1 > WINDOW_W) ? SLOT_W + 1 : WINDOW_W;
  localparam int HALF   = SEQ_COUNT / 2;

  function automatic logic [EW-1:0] mod_dist(input logic [SLOT_W-1:0] from_s,
                                             input logic [SLOT_W-1:0] to_s);
    logic [EW-1:0] f;
    logic [EW-1:0] t;
    f = EW'(from_s);
    t = EW'(to_s);
    if (t >= f) begin
      return t - f;
    end else begin
      return t + EW'(SEQ_COUNT) - f;
    end
  endfunction

  // config registers
  logic [WINDOW_W-1:0]  window_size_r;
  logic [COUNT_W-1:0]   total_packets_r;

  // window state
  logic [SEQ_COUNT-1:0] slot_free_r, slot_free_nxt;
  logic [SLOT_W-1:0]    base_r, base_nxt;
  logic [SLOT_W-1:0]    next_r, next_nxt;
  logic [COUNT_W-1:0]   sent_r, sent_nxt;

  // per-item working registers
  kind_t                kind_r, kind_nxt;
  logic [ACK_W-1:0]     ack_r, ack_nxt;
  logic                 granted_r, granted_nxt;
  logic [FIELD_SLOT_W-1:0] wire_r, wire_nxt;
  logic [COUNT_W-1:0]   pidx_r, pidx_nxt;
  logic                 ignored_r, ignored_nxt;
  logic                 slide_r, slide_nxt;
  logic [EW-1:0]        cnt_r, cnt_nxt;
  out_item_t            out_r;

  logic [EW-1:0]        ws_ext;
  logic [EW-1:0]        w_eff;
  logic [EW-1:0]        dist_bn;
  logic [EW-1:0]        dist_ba;
  logic [CALC_W-1:0]    ack_slot_wide;
  logic [SLOT_W-1:0]    ack_slot;
  logic                 ack_bad;
  logic [SLOT_W-1:0]    base_inc;
  logic [SLOT_W-1:0]    next_inc;
  logic [CALC_W-1:0]    base_wire;
  logic [CALC_W-1:0]    next_wire;
  logic [CALC_W-1:0]    base_wide;
  logic [CALC_W-1:0]    next_wide;

  // window clamped to 1 .. half the sequence space
  assign ws_ext = EW'(window_size_r);
  assign w_eff  = (ws_ext == '0) ? EW'(1) :
                  (ws_ext > EW'(HALF)) ? EW'(HALF) : ws_ext;

  assign dist_bn       = mod_dist(base_r, next_r);
  assign ack_slot_wide = CALC_W'(ack_r) - CALC_W'(1);
  assign ack_slot      = ack_slot_wide[SLOT_W-1:0];
  assign ack_bad       = (ack_r == '0) || (ack_slot_wide >= CALC_W'(SEQ_COUNT));
  assign dist_ba       = mod_dist(base_r, ack_slot);

  assign base_inc = (base_r == SLOT_W'(SEQ_COUNT - 1)) ? '0 : base_r + SLOT_W'(1);
  assign next_inc = (next_r == SLOT_W'(SEQ_COUNT - 1)) ? '0 : next_r + SLOT_W'(1);

  assign base_wire = CALC_W'(base_r) + CALC_W'(1);
  assign next_wire = CALC_W'(next_r) + CALC_W'(1);
  assign base_wide = CALC_W'(base_r);
  assign next_wide = CALC_W'(next_r);

  always_comb begin
    slot_free_nxt = slot_free_r;
    base_nxt      = base_r;
    next_nxt      = next_r;
    sent_nxt      = sent_r;
    kind_nxt      = kind_r;
    ack_nxt       = ack_r;
    granted_nxt   = granted_r;
    wire_nxt      = wire_r;
    pidx_nxt      = pidx_r;
    ignored_nxt   = ignored_r;
    slide_nxt     = slide_r;
    cnt_nxt       = cnt_r;

    if (cmd.load_item) begin
      kind_nxt = in_item.kind;
      ack_nxt  = in_item.ack_number;
    end

    if (cmd.exec) begin
      granted_nxt = 1'b0;
      wire_nxt    = '0;
      pidx_nxt    = '0;
      ignored_nxt = 1'b0;
      slide_nxt   = 1'b0;
      cnt_nxt     = '0;
      unique case (kind_r)
        KIND_START: begin
          slot_free_nxt = '1;
          base_nxt      = '0;
          next_nxt      = '0;
          sent_nxt      = '0;
        end
        KIND_SEND: begin
          if ((sent_r < total_packets_r) && (dist_bn < w_eff) && slot_free_r[next_r]) begin
            granted_nxt           = 1'b1;
            wire_nxt              = next_wire[FIELD_SLOT_W-1:0];
            pidx_nxt              = sent_r;
            slot_free_nxt[next_r] = 1'b0;
            next_nxt              = next_inc;
            sent_nxt              = sent_r + COUNT_W'(1);
          end
        end
        KIND_ACK: begin
          if (ack_bad || (dist_ba >= w_eff)) begin
            ignored_nxt = 1'b1;
          end else begin
            slot_free_nxt[ack_slot] = 1'b1;
            slide_nxt               = (ack_slot == base_r);
          end
        end
        KIND_TIMEOUT: begin
          if (base_r != next_r) begin
            granted_nxt           = 1'b1;
            wire_nxt              = base_wire[FIELD_SLOT_W-1:0];
            pidx_nxt              = sent_r - COUNT_W'(dist_bn);
            slot_free_nxt[base_r] = 1'b0;
          end
        end
        default: begin
          granted_nxt = 1'b0;
        end
      endcase
    end

    if (cmd.slide_step) begin
      base_nxt = base_inc;
      cnt_nxt  = cnt_r + EW'(1);
    end
  end

  // slide stops when no slide was asked for, at the window width, at the next slot or at a busy slot
  assign status.slide_stop = !slide_r || (cnt_r >= w_eff) || (base_r == next_r) ||
                             !slot_free_r[base_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r   <= WINDOW_RESET;
      total_packets_r <= TOTAL_RESET;
      slot_free_r     <= '1;
      base_r          <= '0;
      next_r          <= '0;
      sent_r          <= '0;
      slide_r         <= 1'b0;
      cnt_r           <= '0;
    end else begin
      slot_free_r <= slot_free_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      sent_r      <= sent_nxt;
      slide_r     <= slide_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_WINDOW_SIZE:   window_size_r   <= cfg_data[WINDOW_W-1:0];
          CFG_TOTAL_PACKETS: total_packets_r <= cfg_data[COUNT_W-1:0];
          default:           window_size_r   <= window_size_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    ack_r     <= ack_nxt;
    granted_r <= granted_nxt;
    wire_r    <= wire_nxt;
    pidx_r    <= pidx_nxt;
    ignored_r <= ignored_nxt;
    if (cmd.load_out) begin
      out_r.granted       <= granted_r;
      out_r.wire_seq      <= wire_r;
      out_r.packet_index  <= pidx_r;
      out_r.transfer_done <= (sent_r >= total_packets_r);
      out_r.ack_ignored   <= ignored_r;
      out_r.window_base   <= base_wide[FIELD_SLOT_W-1:0];
      out_r.next_slot     <= next_wide[FIELD_SLOT_W-1:0];
    end
  end

  assign out_item = out_r;

endmodule
